// ----- hw/rtl/bilinear_resize_sampler_unit_macros.svh -----
// assertion macros for the bilinear resize sampler
`ifndef BILINEAR_RESIZE_SAMPLER_UNIT_MACROS_SVH
`define BILINEAR_RESIZE_SAMPLER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BRS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BRS_ASSERT_IMPL(label, ante, cons)
`define BRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/brs_pkg.sv -----
// shared types and constants for the bilinear resize sampler
package brs_pkg;
    localparam int unsigned WEIGHT_ONE = 65536;
    localparam int PIXEL_BITS = 8;

    localparam logic [2:0] CFG_IN_WIDTH = 3'd0;
    localparam logic [2:0] CFG_IN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_BORDER_MODE = 3'd2;
    localparam logic [2:0] CFG_BORDER_VALUE = 3'd3;
    localparam logic [2:0] CFG_CENTER = 3'd4;
    localparam logic [2:0] CFG_HEIGHT_RATIO = 3'd5;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_ADDR,
        ST_READ,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic do_row;
        logic do_addr;
        logic do_read;
        logic do_mul;
        logic do_sum;
        logic set_out;
        logic clr_out;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } stat_t;
endpackage

// ----- hw/rtl/bilinear_resize_sampler_unit.sv -----
// bilinear resize sampler: one load or sample item at a time
// a load writes the store at its transfer; a sample goes through these steps from transfer to result valid
// (row multiply, address, store read, two multiply stages, sum into output register)
// input ready again only after a sample leaves the output state; loads go every cycle
// a result waiting on out_ready holds the next sample in its last stage
// reset clears control and sets configuration to defaults; the image store is undefined until loaded
`include "bilinear_resize_sampler_unit_macros.svh"
module bilinear_resize_sampler_unit #(
    parameter int IMG_W = 64,
    parameter int IMG_H = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [5:0]         pix_x,
    input  logic [5:0]         pix_y,
    input  logic [7:0]         pix_value,
    input  logic [11:0]        out_row,
    input  logic signed [11:0] src_col,
    input  logic [16:0]        dx_frac,
    input  logic [16:0]        dy_frac,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_value
);
    brs_pkg::cmd_t  cmd;
    brs_pkg::stat_t stat;

    brs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    brs_datapath #(
        .IMG_W      (IMG_W),
        .IMG_H      (IMG_H)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .req_type  (req_type),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .pix_value (pix_value),
        .out_row   (out_row),
        .src_col   (src_col),
        .dx_frac   (dx_frac),
        .dy_frac   (dy_frac),
        .out_valid (out_valid),
        .out_value (out_value)
    );

    `BRS_ASSERT_NEXT(a_load_keeps_ready, in_valid && in_ready && !req_type, in_ready)
    `BRS_ASSERT_NEXT(a_sample_starts, in_valid && in_ready && req_type, !in_ready)
    `BRS_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_value))
endmodule

// ----- hw/rtl/brs_ctrl.sv -----
// controller state machine for the sampler
module brs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            req_type,
    input  logic            out_ready,
    input  brs_pkg::stat_t  stat,
    output logic            in_ready,
    output brs_pkg::cmd_t   cmd
);
    brs_pkg::state_t state_reg;
    brs_pkg::state_t state_next;
    logic take;

    // a waiting result only holds a sample in the output state
    assign in_ready = (state_reg == brs_pkg::ST_IDLE);
    assign take = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brs_pkg::ST_IDLE:
            begin
                if (take && req_type == brs_pkg::REQ_SAMPLE)
                begin
                    state_next = brs_pkg::ST_ROW;
                end
            end
            brs_pkg::ST_ROW:  state_next = brs_pkg::ST_ADDR;
            brs_pkg::ST_ADDR: state_next = brs_pkg::ST_READ;
            brs_pkg::ST_READ: state_next = brs_pkg::ST_MUL;
            brs_pkg::ST_MUL:  state_next = brs_pkg::ST_SUM;
            brs_pkg::ST_SUM:  state_next = brs_pkg::ST_OUT;
            brs_pkg::ST_OUT:
            begin
                if (!stat.out_full || out_ready)
                begin
                    state_next = brs_pkg::ST_IDLE;
                end
            end
            default:          state_next = brs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.load_item = take;
        cmd.clr_out = out_ready;
        case (state_reg)
            brs_pkg::ST_ROW:  cmd.do_row = 1'b1;
            brs_pkg::ST_ADDR: cmd.do_addr = 1'b1;
            brs_pkg::ST_READ: cmd.do_read = 1'b1;
            brs_pkg::ST_MUL:  cmd.do_mul = 1'b1;
            brs_pkg::ST_SUM:  cmd.do_sum = 1'b1;
            brs_pkg::ST_OUT:  cmd.set_out = !stat.out_full || out_ready;
            default:          cmd.do_row = 1'b0;
        endcase
    end
endmodule

// ----- hw/rtl/brs_datapath.sv -----
// datapath: image store, row computation, neighbour fetch and blend
module brs_datapath #(
    parameter int IMG_W = 64,
    parameter int IMG_H = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  brs_pkg::cmd_t         cmd,
    output brs_pkg::stat_t        stat,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_idx,
    input  logic [23:0]           cfg_data,
    input  logic                  req_type,
    input  logic [5:0]            pix_x,
    input  logic [5:0]            pix_y,
    input  logic [7:0]            pix_value,
    input  logic [11:0]           out_row,
    input  logic signed [11:0]    src_col,
    input  logic [16:0]           dx_frac,
    input  logic [16:0]           dy_frac,
    output logic                  out_valid,
    output logic [7:0]            out_value
);
    localparam int XW = (IMG_W > 1) ? $clog2(IMG_W) : 1;
    localparam int YW = (IMG_H > 1) ? $clog2(IMG_H) : 1;
    localparam int DEPTH = IMG_W * IMG_H;
    localparam int AW = $clog2(DEPTH);
    localparam int PB = brs_pkg::PIXEL_BITS;

    // configuration
    logic [6:0]  in_width_reg;
    logic [6:0]  in_height_reg;
    logic        border_mode_reg;
    logic [7:0]  border_value_reg;
    logic        center_reg;
    logic [23:0] ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg <= 7'd64;
            in_height_reg <= 7'd64;
            border_mode_reg <= 1'b0;
            border_value_reg <= 8'd0;
            center_reg <= 1'b0;
            ratio_reg <= 24'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                brs_pkg::CFG_IN_WIDTH:     in_width_reg <= cfg_data[6:0];
                brs_pkg::CFG_IN_HEIGHT:    in_height_reg <= cfg_data[6:0];
                brs_pkg::CFG_BORDER_MODE:  border_mode_reg <= cfg_data[0];
                brs_pkg::CFG_BORDER_VALUE: border_value_reg <= cfg_data[7:0];
                brs_pkg::CFG_CENTER:       center_reg <= cfg_data[0];
                brs_pkg::CFG_HEIGHT_RATIO: ratio_reg <= cfg_data;
                default:                   ratio_reg <= ratio_reg;
            endcase
        end
    end

    // effective size clamped to 1..IMG
    logic signed [13:0] w_eff;
    logic signed [13:0] h_eff;
    always_comb
    begin
        w_eff = 14'(in_width_reg);
        h_eff = 14'(in_height_reg);
        if (in_width_reg == 7'd0) w_eff = 14'sd1;
        else if ({7'd0, in_width_reg} > 14'(IMG_W)) w_eff = 14'(IMG_W);
        if (in_height_reg == 7'd0) h_eff = 14'sd1;
        else if ({7'd0, in_height_reg} > 14'(IMG_H)) h_eff = 14'(IMG_H);
    end

    // item capture
    logic [11:0]        row_reg;
    logic signed [11:0] col_reg;
    logic [16:0]        dx_reg;
    logic [16:0]        dy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            row_reg <= out_row;
            col_reg <= src_col;
            dx_reg <= (dx_frac > 17'(brs_pkg::WEIGHT_ONE)) ? 17'(brs_pkg::WEIGHT_ONE) : dx_frac;
            dy_reg <= (dy_frac > 17'(brs_pkg::WEIGHT_ONE)) ? 17'(brs_pkg::WEIGHT_ONE) : dy_frac;
        end
    end

    // image store, four copies so all neighbours read in one cycle
    logic [PB-1:0] mem0 [DEPTH];
    logic [PB-1:0] mem1 [DEPTH];
    logic [PB-1:0] mem2 [DEPTH];
    logic [PB-1:0] mem3 [DEPTH];
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    assign wr_en = cmd.load_item && req_type == brs_pkg::REQ_LOAD
        && ({26'd0, pix_x} < 32'(IMG_W)) && ({26'd0, pix_y} < 32'(IMG_H));
    assign wr_addr = AW'(32'(pix_y) * 32'(IMG_W) + 32'(pix_x));

    // source row: t = (2*row + c) * r - c*65536, floor by 2^17
    logic signed [40:0] t_reg;
    logic signed [23:0] yi;
    assign yi = 24'(t_reg >>> 17);

    always_ff @(posedge clk)
    begin
        if (cmd.do_row)
        begin
            t_reg <= $signed(41'({row_reg, center_reg}) * 41'(ratio_reg))
                - (center_reg ? 41'sd65536 : 41'sd0);
        end
    end

    // neighbour coordinates and address stage
    logic [AW-1:0] addr_reg [4];
    logic          oob_reg [4];
    logic          oob_d_reg [4];
    logic [PB-1:0] rd_reg [4];
    logic [PB-1:0] a_pix [4];

    always_ff @(posedge clk)
    begin
        if (cmd.do_addr)
        begin
            for (int k = 0; k < 4; k++)
            begin
                logic signed [25:0] xk;
                logic signed [25:0] yk;
                logic               o;
                logic [AW-1:0]      ak;
                xk = 26'(col_reg) + 26'(k % 2);
                yk = 26'(yi) + 26'(k / 2);
                o = (xk < 0) || (xk >= 26'(w_eff)) || (yk < 0) || (yk >= 26'(h_eff));
                if (border_mode_reg)
                begin
                    if (xk < 0) xk = 26'sd0;
                    else if (xk >= 26'(w_eff)) xk = 26'(w_eff) - 26'sd1;
                    if (yk < 0) yk = 26'sd0;
                    else if (yk >= 26'(h_eff)) yk = 26'(h_eff) - 26'sd1;
                    o = 1'b0;
                end
                // address is a don't-care for a border neighbour
                ak = o ? '0 : AW'(32'(yk[YW-1:0]) * 32'(IMG_W) + 32'(xk[XW-1:0]));
                oob_reg[k] <= o;
                addr_reg[k] <= ak;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem0[wr_addr] <= pix_value[PB-1:0];
            mem1[wr_addr] <= pix_value[PB-1:0];
            mem2[wr_addr] <= pix_value[PB-1:0];
            mem3[wr_addr] <= pix_value[PB-1:0];
        end
        if (cmd.do_read)
        begin
            rd_reg[0] <= mem0[addr_reg[0]];
            rd_reg[1] <= mem1[addr_reg[1]];
            rd_reg[2] <= mem2[addr_reg[2]];
            rd_reg[3] <= mem3[addr_reg[3]];
            oob_d_reg <= oob_reg;
        end
    end

    // weights and products
    logic [16:0]      wx0;
    logic [16:0]      wy0;
    logic [PB+16:0]   p_reg [4];
    logic [PB+33:0]   q_reg [4];
    logic [PB+35:0]   sum;

    assign wx0 = 17'(brs_pkg::WEIGHT_ONE) - dx_reg;
    assign wy0 = 17'(brs_pkg::WEIGHT_ONE) - dy_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            a_pix[k] = oob_d_reg[k] ? PB'(border_value_reg) : rd_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_mul)
        begin
            p_reg[0] <= a_pix[0] * wx0;
            p_reg[1] <= a_pix[1] * dx_reg;
            p_reg[2] <= a_pix[2] * wx0;
            p_reg[3] <= a_pix[3] * dx_reg;
        end
        if (cmd.do_sum)
        begin
            q_reg[0] <= p_reg[0] * wy0;
            q_reg[1] <= p_reg[1] * wy0;
            q_reg[2] <= p_reg[2] * dy_reg;
            q_reg[3] <= p_reg[3] * dy_reg;
        end
    end

    assign sum = (PB+36)'(q_reg[0]) + (PB+36)'(q_reg[1])
        + (PB+36)'(q_reg[2]) + (PB+36)'(q_reg[3]);

    // output register
    logic       out_full_reg;
    logic [7:0] out_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (cmd.set_out)
        begin
            out_full_reg <= 1'b1;
        end
        else if (cmd.clr_out)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_out)
        begin
            out_value_reg <= sum[39:32];
        end
    end

    assign stat.out_full = out_full_reg;
    assign out_valid = out_full_reg;
    assign out_value = out_value_reg;
endmodule
